// ===== rtl/core/sqllex_pkg.sv =====
`timescale 1ns / 1ps
package sqllex_pkg;

  localparam int MAX_TEXT_DEF          = 65536;
  localparam int MAX_KEYWORD_CHARS_DEF = 14;

  // Keyword words are held right-justified, upper bytes zero.
  localparam int KW_ROM_CHARS = 32;
  localparam int KW_NUM       = 98;
  typedef logic [8*KW_ROM_CHARS-1:0] kw_word_t;

  localparam kw_word_t KW_ROM [KW_NUM] = '{
    "SELECT", "FROM", "WHERE", "AND", "OR", "NOT", "IN", "IS", "AS",
    "INSERT", "INTO", "VALUES", "UPDATE", "SET", "DELETE", "JOIN", "LEFT",
    "RIGHT", "INNER", "OUTER", "FULL", "CROSS", "ON", "GROUP", "BY",
    "ORDER", "HAVING", "UNION", "ALL", "INTERSECT", "MINUS", "DISTINCT",
    "CURSOR", "PROCEDURE", "FUNCTION", "BEGIN", "END", "DECLARE", "RETURN",
    "IF", "THEN", "ELSE", "ELSIF", "LOOP", "FOR", "WHILE", "EXIT", "WHEN",
    "CASE", "EXCEPTION", "RAISE", "OPEN", "FETCH", "CLOSE", "NULL", "LIKE",
    "BETWEEN", "EXISTS", "COUNT", "SUM", "AVG", "MIN", "MAX", "NVL",
    "DECODE", "SUBSTR", "INSTR", "TO_CHAR", "TO_DATE", {"TO_", "NUMBER"}, "UPPER",
    "LOWER", "TRIM", "RTRIM", "LTRIM", "SYSDATE", "ROWNUM", "ROWID",
    "VARCHAR2", "NUMBER", "DATE", "BOOLEAN", "CHAR", "CLOB", "BLOB",
    "INTEGER", "TIMESTAMP", "TYPE", "ROWTYPE", "RECORD", "TABLE", "OF",
    "INDEX", {"BINARY_", "INTEGER"}, {"PLS_", "INTEGER"}, "TRUE", "FALSE", "DEFAULT"
  };

  typedef enum logic [1:0] {
    CLS_COMMENT = 2'd0,
    CLS_STRING  = 2'd1,
    CLS_KEYWORD = 2'd2,
    CLS_NUMBER  = 2'd3
  } tok_cls_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic [15:0] start;
    logic [16:0] stop;
    logic        last;
    logic        ovf;
  } tok_res_t;

endpackage

// ===== rtl/core/sqllex_kwmatch.sv =====
`timescale 1ns / 1ps
module sqllex_kwmatch #(
  parameter int MAX_KEYWORD_CHARS = sqllex_pkg::MAX_KEYWORD_CHARS_DEF,
  localparam int LW = $clog2(MAX_KEYWORD_CHARS + 2)
) (
  input  logic [8*MAX_KEYWORD_CHARS-1:0] word,
  input  logic [LW-1:0]                  len,
  output logic                           hit
);

  sqllex_pkg::kw_word_t word_ext;
  logic                 any;

  assign word_ext = sqllex_pkg::kw_word_t'(word);

  // ROM words contain no zero byte, so equality of the padded words also
  // implies equal lengths.
  always_comb begin
    any = 1'b0;
    for (int k = 0; k < sqllex_pkg::KW_NUM; k++) begin
      if (word_ext == sqllex_pkg::KW_ROM[k]) any = 1'b1;
    end
  end

  assign hit = any && (len != '0) && (int'(len) <= MAX_KEYWORD_CHARS);

endmodule

// ===== rtl/core/sqllex_ofifo.sv =====
`timescale 1ns / 1ps
module sqllex_ofifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           push_n,
  input  sqllex_pkg::tok_res_t push_a,
  input  sqllex_pkg::tok_res_t push_b,
  input  logic                 pop,
  output logic                 not_empty,
  output logic                 room2,
  output sqllex_pkg::tok_res_t head
);

  sqllex_pkg::tok_res_t mem [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] wp1;

  assign wp1       = wp_r + 2'd1;
  assign not_empty = cnt_r != 3'd0;
  assign room2     = cnt_r <= 3'd2;
  assign head      = mem[rp_r];
  assign cnt_nxt   = cnt_r + {1'b0, push_n} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wp_r] <= push_a;
    if (push_n == 2'd2) mem[wp1]  <= push_b;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + push_n;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/sqllex_scan.sv =====
`timescale 1ns / 1ps
module sqllex_scan #(
  parameter int MAX_TEXT          = sqllex_pkg::MAX_TEXT_DEF,
  parameter int MAX_KEYWORD_CHARS = sqllex_pkg::MAX_KEYWORD_CHARS_DEF,
  localparam int PW = $clog2(MAX_TEXT + 1),
  localparam int LW = $clog2(MAX_KEYWORD_CHARS + 2),
  localparam int WB = 8 * MAX_KEYWORD_CHARS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic [15:0]          code_unit,
  input  logic                 text_end,
  output logic [1:0]           push_n,
  output sqllex_pkg::tok_res_t push_a,
  output sqllex_pkg::tok_res_t push_b
);

  localparam int LIM_START = (MAX_TEXT - 1 < 65535) ? MAX_TEXT - 1 : 65535;
  localparam int LIM_END   = (MAX_TEXT < 65536) ? MAX_TEXT : 65536;

  typedef enum logic [2:0] {
    M_NORMAL, M_BLOCK, M_LINE, M_STRING, M_WORD, M_NUMBER
  } mode_t;
  typedef enum logic [2:0] {
    H_NONE, H_SLASH, H_DASH, H_STAR, H_QUOTE
  } held_t;

  typedef struct packed {
    logic        v;
    logic        kw;
    logic [1:0]  cls;
    logic [15:0] start;
    logic [16:0] stop;
  } ev_t;

  mode_t          mode_r, mode_nxt;
  held_t          held_r, held_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [15:0]    tb_r, tb_nxt;
  logic [LW-1:0]  wl_r, wl_nxt;
  logic [WB-1:0]  ws_r, ws_nxt;

  logic [31:0] p32, p1;
  logic [15:0] begin_pos;
  logic [16:0] end_here, end_after;
  logic        ovf;
  logic [7:0]  c8;
  logic        ascii, is_alpha, is_digit, is_wordc;
  logic        consumed;
  ev_t         ev0, ev1;
  logic [WB-1:0] kw_word;
  logic [LW-1:0] kw_len;
  logic        kw_hit, a_ok, b_ok;
  sqllex_pkg::tok_res_t ra, rb;

  assign p32       = 32'(pos_r);
  assign p1        = p32 + 32'd1;
  assign begin_pos = (p32 < LIM_START) ? p32[15:0] : 16'(LIM_START);
  assign end_here  = (p32 < LIM_END) ? p32[16:0] : 17'(LIM_END);
  assign end_after = (p1 < LIM_END) ? p1[16:0] : 17'(LIM_END);
  assign ovf       = p32 >= MAX_TEXT;

  assign c8       = code_unit[7:0];
  assign ascii    = code_unit[15:8] == 8'd0;
  assign is_alpha = ascii && (c8 inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  assign is_digit = ascii && (c8 inside {[8'h30:8'h39]});
  assign is_wordc = is_alpha || is_digit ||
                    (ascii && (c8 inside {8'h5F, 8'h24, 8'h23}));

  always_comb begin
    mode_nxt = mode_r;
    held_nxt = held_r;
    pos_nxt  = pos_r;
    tb_nxt   = tb_r;
    wl_nxt   = wl_r;
    ws_nxt   = ws_r;
    consumed = 1'b0;
    ev0      = '0;
    ev1      = '0;

    case (mode_r)
      M_BLOCK: begin
        if (held_r == H_STAR && code_unit == 16'h002F) begin
          ev0      = '{1'b1, 1'b0, sqllex_pkg::CLS_COMMENT, tb_r, end_after};
          mode_nxt = M_NORMAL;
          held_nxt = H_NONE;
        end else begin
          held_nxt = (code_unit == 16'h002A) ? H_STAR : H_NONE;
        end
        consumed = 1'b1;
      end
      M_LINE: begin
        if (code_unit == 16'h000D || code_unit == 16'h000A) begin
          ev0      = '{1'b1, 1'b0, sqllex_pkg::CLS_COMMENT, tb_r, end_here};
          mode_nxt = M_NORMAL;
        end else begin
          consumed = 1'b1;
        end
      end
      M_STRING: begin
        if (held_r == H_QUOTE) begin
          held_nxt = H_NONE;
          if (code_unit == 16'h0027) begin
            consumed = 1'b1;
          end else begin
            ev0      = '{1'b1, 1'b0, sqllex_pkg::CLS_STRING, tb_r, end_here};
            mode_nxt = M_NORMAL;
          end
        end else begin
          if (code_unit == 16'h0027) held_nxt = H_QUOTE;
          consumed = 1'b1;
        end
      end
      M_WORD: begin
        if (is_wordc) begin
          ws_nxt = {ws_nxt[WB-9:0], (c8 inside {[8'h61:8'h7A]}) ? c8 - 8'd32 : c8};
          if (int'(wl_nxt) <= MAX_KEYWORD_CHARS) wl_nxt = wl_nxt + LW'(1);
          consumed = 1'b1;
        end else begin
          ev0      = '{1'b1, 1'b1, sqllex_pkg::CLS_KEYWORD, tb_r, end_here};
          wl_nxt   = '0;
          mode_nxt = M_NORMAL;
        end
      end
      M_NUMBER: begin
        if (is_digit || code_unit == 16'h002E || code_unit == 16'h0045 ||
            code_unit == 16'h0065) begin
          consumed = 1'b1;
        end else begin
          ev0      = '{1'b1, 1'b0, sqllex_pkg::CLS_NUMBER, tb_r, end_here};
          mode_nxt = M_NORMAL;
        end
      end
      default: begin
        mode_nxt = M_NORMAL;
        if (held_r == H_SLASH && code_unit == 16'h002A) begin
          mode_nxt = M_BLOCK;
          consumed = 1'b1;
        end else if (held_r == H_DASH && code_unit == 16'h002D) begin
          mode_nxt = M_LINE;
          consumed = 1'b1;
        end
        held_nxt = H_NONE;
      end
    endcase

    if (!consumed) begin
      if (code_unit == 16'h002F || code_unit == 16'h002D) begin
        held_nxt = (code_unit == 16'h002F) ? H_SLASH : H_DASH;
        tb_nxt   = begin_pos;
      end else if (code_unit == 16'h0027) begin
        mode_nxt = M_STRING;
        tb_nxt   = begin_pos;
      end else if (is_alpha || code_unit == 16'h005F) begin
        mode_nxt = M_WORD;
        tb_nxt   = begin_pos;
        ws_nxt   = {{(WB-8){1'b0}}, (c8 inside {[8'h61:8'h7A]}) ? c8 - 8'd32 : c8};
        wl_nxt   = LW'(1);
      end else if (is_digit) begin
        mode_nxt = M_NUMBER;
        tb_nxt   = begin_pos;
      end
    end

    if (text_end) begin
      case (mode_nxt)
        M_BLOCK, M_LINE:
          ev1 = '{1'b1, 1'b0, sqllex_pkg::CLS_COMMENT, tb_nxt, end_after};
        M_STRING:
          ev1 = '{1'b1, 1'b0, sqllex_pkg::CLS_STRING, tb_nxt, end_after};
        M_WORD:
          ev1 = '{1'b1, 1'b1, sqllex_pkg::CLS_KEYWORD, tb_nxt, end_after};
        M_NUMBER:
          ev1 = '{1'b1, 1'b0, sqllex_pkg::CLS_NUMBER, tb_nxt, end_after};
        default: ev1 = '0;
      endcase
    end

    // At most one word ends per character; the keyword lookup sees the
    // buffer as it stands at that point.
    kw_word = ev0.kw ? ws_r : ws_nxt;
    kw_len  = ev0.kw ? wl_r : wl_nxt;

    if (text_end) begin
      mode_nxt = M_NORMAL;
      held_nxt = H_NONE;
      pos_nxt  = '0;
      tb_nxt   = '0;
      wl_nxt   = '0;
    end else if (p32 < MAX_TEXT) begin
      pos_nxt = p1[PW-1:0];
    end
  end

  sqllex_kwmatch #(.MAX_KEYWORD_CHARS(MAX_KEYWORD_CHARS)) u_kw (
    .word (kw_word),
    .len  (kw_len),
    .hit  (kw_hit)
  );

  assign a_ok = ev0.v && (!ev0.kw || kw_hit);
  assign b_ok = ev1.v && (!ev1.kw || kw_hit);

  assign ra = '{ev0.cls, ev0.start, ev0.stop, !b_ok, ovf};
  assign rb = '{ev1.cls, ev1.start, ev1.stop, 1'b1, ovf};

  always_comb begin
    push_a = a_ok ? ra : rb;
    push_b = rb;
    if (!acc) push_n = 2'd0;
    else      push_n = {1'b0, a_ok} + {1'b0, b_ok};
  end

  always_ff @(posedge clk) begin
    if (acc) ws_r <= ws_nxt;
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      held_r <= H_NONE;
      pos_r  <= '0;
      tb_r   <= '0;
      wl_r   <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      pos_r  <= pos_nxt;
      tb_r   <= tb_nxt;
      wl_r   <= wl_nxt;
    end
  end

endmodule

// ===== rtl/core/sql_lexer_token_classifier_core.sv =====
`timescale 1ns / 1ps
// A token is written into the output queue when the character that closes it is accepted.
// Throughput: one character per cycle; a character may yield two token beats, drained
// by a four-entry output queue that stalls the input while fewer than two slots are free.
// Reset: synchronous, active low; the lexer returns to normal scanning at offset zero and
// the output queue empties.
module sql_lexer_token_classifier_core #(
  parameter int MAX_TEXT          = sqllex_pkg::MAX_TEXT_DEF,
  parameter int MAX_KEYWORD_CHARS = sqllex_pkg::MAX_KEYWORD_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_code_unit,
  input  logic        in_text_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_token_class,
  output logic [15:0] out_token_start,
  output logic [16:0] out_token_end,
  output logic        out_run_last,
  output logic        out_offset_overflow
);

  logic                 acc, room2;
  logic [1:0]           push_n;
  sqllex_pkg::tok_res_t push_a, push_b, head;

  assign in_stall = !room2;
  assign acc      = in_valid && room2;

  sqllex_scan #(
    .MAX_TEXT          (MAX_TEXT),
    .MAX_KEYWORD_CHARS (MAX_KEYWORD_CHARS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .code_unit (in_code_unit),
    .text_end  (in_text_end),
    .push_n    (push_n),
    .push_a    (push_a),
    .push_b    (push_b)
  );

  sqllex_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_a    (push_a),
    .push_b    (push_b),
    .pop       (out_valid && !out_stall),
    .not_empty (out_valid),
    .room2     (room2),
    .head      (head)
  );

  assign out_token_class     = head.cls;
  assign out_token_start     = head.start;
  assign out_token_end       = head.stop;
  assign out_run_last        = head.last;
  assign out_offset_overflow = head.ovf;

endmodule

// ===== dv/sqllex_checker.sv =====
`timescale 1ns / 1ps
module sqllex_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] in_code_unit,
  input  logic        in_text_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_token_class,
  input  logic [15:0] out_token_start,
  input  logic [16:0] out_token_end,
  input  logic        out_run_last,
  input  logic        out_offset_overflow,
  output int          fail_count,
  output int          tokens_pending,
  output logic        beat_seen
);

  localparam int TEXT_LIMIT = sqllex_pkg::MAX_TEXT_DEF;
  localparam int WORD_LIMIT = sqllex_pkg::MAX_KEYWORD_CHARS_DEF;

  localparam logic [2:0] LX_NORMAL = 3'd0;
  localparam logic [2:0] LX_BLOCK  = 3'd1;
  localparam logic [2:0] LX_LINE   = 3'd2;
  localparam logic [2:0] LX_STRING = 3'd3;
  localparam logic [2:0] LX_WORD   = 3'd4;
  localparam logic [2:0] LX_NUMBER = 3'd5;

  localparam logic [2:0] HOLD_NONE  = 3'd0;
  localparam logic [2:0] HOLD_SLASH = 3'd1;
  localparam logic [2:0] HOLD_DASH  = 3'd2;
  localparam logic [2:0] HOLD_STAR  = 3'd3;
  localparam logic [2:0] HOLD_QUOTE = 3'd4;

  localparam logic [15:0] CH_SLASH = 16'h2F;
  localparam logic [15:0] CH_STAR  = 16'h2A;
  localparam logic [15:0] CH_DASH  = 16'h2D;
  localparam logic [15:0] CH_QUOTE = 16'h27;
  localparam logic [15:0] CH_CR    = 16'h0D;
  localparam logic [15:0] CH_LF    = 16'h0A;

  logic [2:0] lx_mode;
  logic [2:0] lx_hold;
  int         lx_pos;
  int         lx_begin;
  logic [7:0] lx_chars [WORD_LIMIT];
  int         lx_len;
  logic       cur_ovf;

  sqllex_pkg::tok_res_t expected_tokens [$];
  sqllex_pkg::tok_res_t step_tokens [$];

  function automatic bit is_alpha(logic [15:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_digit(logic [15:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word_char(logic [15:0] c);
    return is_alpha(c) || is_digit(c) || c == "_" || c == "$" || c == "#";
  endfunction

  task automatic add_token(logic [1:0] cls, int s, int e);
    sqllex_pkg::tok_res_t t;
    if (step_tokens.size() < 2) begin
      t.cls   = cls;
      t.start = s[15:0];
      t.stop  = e[16:0];
      t.last  = 1'b0;
      t.ovf   = cur_ovf;
      step_tokens = {step_tokens, t};
    end
  endtask

  function automatic bit word_is_keyword();
    sqllex_pkg::kw_word_t w;
    w = '0;
    if (lx_len == 0 || lx_len > WORD_LIMIT) return 1'b0;
    for (int j = 0; j < lx_len; j++) w = (w << 8) | sqllex_pkg::kw_word_t'(lx_chars[j]);
    for (int k = 0; k < sqllex_pkg::KW_NUM; k++) begin
      if (sqllex_pkg::KW_ROM[k] == w) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic close_word(int e);
    if (word_is_keyword()) add_token(sqllex_pkg::CLS_KEYWORD, lx_begin, e);
    lx_len = 0;
  endtask

  task automatic append_char(logic [15:0] c);
    logic [15:0] u;
    u = (c >= "a" && c <= "z") ? c - 16'd32 : c;
    if (lx_len < WORD_LIMIT) lx_chars[lx_len] = u[7:0];
    if (lx_len <= WORD_LIMIT) lx_len++;
  endtask

  task automatic clear_lexer();
    lx_mode  = LX_NORMAL;
    lx_hold  = HOLD_NONE;
    lx_pos   = 0;
    lx_begin = 0;
    lx_len   = 0;
  endtask

  task automatic lex_char(logic [15:0] c, logic fin);
    int  p;
    int  bgn;
    int  end_here;
    int  end_after;
    bit  used;
    p         = lx_pos;
    bgn       = (p < TEXT_LIMIT - 1) ? p : TEXT_LIMIT - 1;
    if (bgn > 65535) bgn = 65535;
    end_here  = (p < TEXT_LIMIT) ? p : TEXT_LIMIT;
    end_after = (p + 1 < TEXT_LIMIT) ? p + 1 : TEXT_LIMIT;
    if (end_here > 65536) end_here = 65536;
    if (end_after > 65536) end_after = 65536;
    used      = 1'b0;
    cur_ovf   = (p >= TEXT_LIMIT);
    step_tokens.delete();

    case (lx_mode)
      LX_BLOCK: begin
        if (lx_hold == HOLD_STAR && c == CH_SLASH) begin
          add_token(sqllex_pkg::CLS_COMMENT, lx_begin, end_after);
          lx_mode = LX_NORMAL;
          lx_hold = HOLD_NONE;
        end else begin
          lx_hold = (c == CH_STAR) ? HOLD_STAR : HOLD_NONE;
        end
        used = 1'b1;
      end
      LX_LINE: begin
        if (c == CH_CR || c == CH_LF) begin
          add_token(sqllex_pkg::CLS_COMMENT, lx_begin, end_here);
          lx_mode = LX_NORMAL;
        end else begin
          used = 1'b1;
        end
      end
      LX_STRING: begin
        if (lx_hold == HOLD_QUOTE) begin
          lx_hold = HOLD_NONE;
          if (c == CH_QUOTE) begin
            used = 1'b1;
          end else begin
            add_token(sqllex_pkg::CLS_STRING, lx_begin, end_here);
            lx_mode = LX_NORMAL;
          end
        end else begin
          if (c == CH_QUOTE) lx_hold = HOLD_QUOTE;
          used = 1'b1;
        end
      end
      LX_WORD: begin
        if (is_word_char(c)) begin
          append_char(c);
          used = 1'b1;
        end else begin
          close_word(end_here);
          lx_mode = LX_NORMAL;
        end
      end
      LX_NUMBER: begin
        if (is_digit(c) || c == "." || c == "E" || c == "e") begin
          used = 1'b1;
        end else begin
          add_token(sqllex_pkg::CLS_NUMBER, lx_begin, end_here);
          lx_mode = LX_NORMAL;
        end
      end
      default: begin
        lx_mode = LX_NORMAL;
        if (lx_hold == HOLD_SLASH && c == CH_STAR) begin
          lx_mode = LX_BLOCK;
          used = 1'b1;
        end else if (lx_hold == HOLD_DASH && c == CH_DASH) begin
          lx_mode = LX_LINE;
          used = 1'b1;
        end
        lx_hold = HOLD_NONE;
      end
    endcase

    if (!used) begin
      if (c == CH_SLASH || c == CH_DASH) begin
        lx_hold  = (c == CH_SLASH) ? HOLD_SLASH : HOLD_DASH;
        lx_begin = bgn;
      end else if (c == CH_QUOTE) begin
        lx_mode  = LX_STRING;
        lx_begin = bgn;
      end else if (is_alpha(c) || c == "_") begin
        lx_mode  = LX_WORD;
        lx_begin = bgn;
        lx_len   = 0;
        append_char(c);
      end else if (is_digit(c)) begin
        lx_mode  = LX_NUMBER;
        lx_begin = bgn;
      end
    end

    if (fin) begin
      case (lx_mode)
        LX_BLOCK, LX_LINE: add_token(sqllex_pkg::CLS_COMMENT, lx_begin, end_after);
        LX_STRING:         add_token(sqllex_pkg::CLS_STRING, lx_begin, end_after);
        LX_WORD:           close_word(end_after);
        LX_NUMBER:         add_token(sqllex_pkg::CLS_NUMBER, lx_begin, end_after);
        default: ;
      endcase
      clear_lexer();
    end else if (p < TEXT_LIMIT) begin
      lx_pos = p + 1;
    end

    foreach (step_tokens[k]) begin
      step_tokens[k].last = (k == step_tokens.size() - 1);
      expected_tokens = {expected_tokens, step_tokens[k]};
    end
  endtask

  task automatic compare_token();
    sqllex_pkg::tok_res_t t;
    if (expected_tokens.size() == 0) begin
      $display("%0t: unexpected token beat cls=%0d start=%0d end=%0d last=%0b ovf=%0b",
               $time, out_token_class, out_token_start, out_token_end, out_run_last,
               out_offset_overflow);
      fail_count++;
    end else begin
      t = expected_tokens.pop_front();
      if (t.cls !== out_token_class || t.start !== out_token_start ||
          t.stop !== out_token_end || t.last !== out_run_last ||
          t.ovf !== out_offset_overflow) begin
        $display("%0t: token mismatch expected cls=%0d start=%0d end=%0d last=%0b ovf=%0b",
                 $time, t.cls, t.start, t.stop, t.last, t.ovf);
        $display("%0t:                actual   cls=%0d start=%0d end=%0d last=%0b ovf=%0b",
                 $time, out_token_class, out_token_start, out_token_end, out_run_last,
                 out_offset_overflow);
        fail_count++;
      end
    end
  endtask

  initial begin
    fail_count     = 0;
    tokens_pending = 0;
    clear_lexer();
  end

  always @(posedge clk) begin
    logic seen;
    seen = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        compare_token();
        seen = 1'b1;
      end
      if (in_valid && !in_stall) begin
        lex_char(in_code_unit, in_text_end);
        seen = 1'b1;
      end
    end
    tokens_pending = expected_tokens.size();
    beat_seen <= seen;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_code_unit;
  logic        in_text_end;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_token_class;
  logic [15:0] out_token_start;
  logic [16:0] out_token_end;
  logic        out_run_last;
  logic        out_offset_overflow;
  int          fail_count;
  int          tokens_pending;
  logic        beat_seen;

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_off_req;
  int  quiet_cycles;
  int  chars_sent;

  localparam int WATCHDOG_LIMIT = 5000;

  sql_lexer_token_classifier_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_code_unit(in_code_unit), .in_text_end(in_text_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_token_class(out_token_class), .out_token_start(out_token_start),
    .out_token_end(out_token_end), .out_run_last(out_run_last),
    .out_offset_overflow(out_offset_overflow)
  );

  sqllex_checker lex_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_code_unit(in_code_unit), .in_text_end(in_text_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_token_class(out_token_class), .out_token_start(out_token_start),
    .out_token_end(out_token_end), .out_run_last(out_run_last),
    .out_offset_overflow(out_offset_overflow),
    .fail_count(fail_count), .tokens_pending(tokens_pending), .beat_seen(beat_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: random stalls, or one long hold-off counted here.
  initial begin
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || beat_seen) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL sql_lexer_token_classifier_core");
      $finish;
    end
  end

  task automatic send_char(logic [15:0] c, logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_code_unit <= c;
    in_text_end  <= fin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_text(string s, bit fin);
    for (int i = 0; i < s.len(); i++) send_char(16'(s[i]), fin && i == s.len() - 1);
  endtask

  function automatic logic [15:0] noise_char();
    case ($urandom_range(11))
      0:       return 16'($urandom_range(65535));
      1:       return 16'("/");
      2:       return 16'("*");
      3:       return 16'("-");
      4:       return 16'("'");
      5:       return ($urandom_range(1)) ? 16'h0D : 16'h0A;
      6:       return 16'(" ");
      7:       return 16'("0" + $urandom_range(9));
      8:       return 16'("a" + $urandom_range(25));
      9: begin
        case ($urandom_range(4))
          0: return 16'("$");
          1: return 16'("#");
          2: return 16'("_");
          3: return 16'(".");
          default: return 16'("E");
        endcase
      end
      10:      return 16'h0100 | 16'("A" + $urandom_range(25));
      default: return 16'("A" + $urandom_range(25));
    endcase
  endfunction

  // Mostly well-formed fragments with random content, and some noise.
  task automatic send_fragment();
    sqllex_pkg::kw_word_t w;
    int         n;
    logic [7:0] b;
    logic [15:0] c;
    case ($urandom_range(9))
      0, 1, 2: begin
        w = sqllex_pkg::KW_ROM[$urandom_range(sqllex_pkg::KW_NUM - 1)];
        n = 0;
        while (n < sqllex_pkg::KW_ROM_CHARS && w[8*n +: 8] != 0) n++;
        for (int j = n - 1; j >= 0; j--) begin
          b = w[8*j +: 8];
          c = (b >= "A" && b <= "Z" && $urandom_range(1)) ? 16'(b) + 16'd32 : 16'(b);
          send_char(c, $urandom_range(39) == 0);
        end
        if ($urandom_range(3) == 0) send_char(noise_char(), 1'b0);
        else send_char(16'(" "), $urandom_range(19) == 0);
      end
      3: begin
        send_char(16'("0" + $urandom_range(9)), 1'b0);
        repeat ($urandom_range(4)) send_char(noise_char(), $urandom_range(29) == 0);
      end
      4: begin
        send_char(16'("'"), 1'b0);
        repeat ($urandom_range(5)) send_char(noise_char(), $urandom_range(39) == 0);
        send_char(16'("'"), $urandom_range(9) == 0);
      end
      5: begin
        send_char(16'("/"), 1'b0);
        send_char(16'("*"), 1'b0);
        repeat ($urandom_range(5)) send_char(noise_char(), $urandom_range(39) == 0);
        send_char(16'("*"), 1'b0);
        send_char(16'("/"), $urandom_range(9) == 0);
      end
      6: begin
        send_char(16'("-"), 1'b0);
        send_char(16'("-"), 1'b0);
        repeat ($urandom_range(5)) send_char(noise_char(), $urandom_range(39) == 0);
        send_char(16'h0A, $urandom_range(9) == 0);
      end
      default: send_char(noise_char(), $urandom_range(24) == 0);
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (tokens_pending != 0);
  endtask

  initial begin
    in_valid      = 1'b0;
    in_code_unit  = '0;
    in_text_end   = 1'b0;
    send_idle_pct = 14;
    recv_idle_pct = 62;
    hold_off_req  = 1'b0;
    quiet_cycles  = 0;
    chars_sent    = 0;
    rst_n         = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: keywords, comments, strings, numbers, openers and text ends.
    send_text("select SeLeCt x ", 1'b0);
    send_text("/*/ a*/", 1'b0);
    send_text("--c\r", 1'b0);
    send_text("'it''s' 12.5E3 BINARY_", 1'b0);
    send_text("INTEGER1 binary_", 1'b0);
    send_text("integer ", 1'b0);
    send_text("/ - v$#_", 1'b0);
    send_char(16'hFFFF, 1'b0);
    send_char(16'h0000, 1'b0);
    send_text("'open", 1'b1);
    send_text("/*x", 1'b1);
    send_text("--y", 1'b1);
    send_text("99", 1'b1);
    send_text("FROM", 1'b1);
    send_text("/", 1'b1);
    send_text("-", 1'b1);
    send_text("'a'", 1'b0);
    send_char(16'("5"), 1'b1);
    wait_drained();

    // Long hold-off while the sender keeps going, so the block backs up.
    hold_off_req = 1'b1;
    repeat (40) send_fragment();
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 62 : 0;
      recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 14 : 0;
      chars_sent = 0;
      while (chars_sent < 110) send_fragment();
      send_char(16'(" "), 1'b1);
      wait_drained();
    end

    // A closing run of short texts.
    send_text("' 7 -- z", 1'b1);
    send_text("SET ", 1'b1);

    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && tokens_pending == 0) begin
      $display("PASS sql_lexer_token_classifier_core");
    end else begin
      $display("FAIL sql_lexer_token_classifier_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sqllex_pkg.sv
rtl/core/sqllex_kwmatch.sv
rtl/core/sqllex_ofifo.sv
rtl/core/sqllex_scan.sv
rtl/core/sql_lexer_token_classifier_core.sv
dv/sqllex_checker.sv
dv/testbench.sv
